// ===== sv/sbda_pkg.sv =====
// Shared types and constants for the signed binary to decimal ASCII converter.
package sbda_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned NumDigits  = 20;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned StepWidth  = $clog2(ValueWidth);
  localparam int unsigned DigCntWidth = $clog2(NumDigits + 1);

  localparam logic [CharWidth-1:0] CharZero  = 6'd48;
  localparam logic [CharWidth-1:0] CharMinus = 6'd45;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_shift;
    logic emit_sign;
    logic emit_digit;
  } sbda_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic one_left;
    logic negative;
    logic out_free;
  } sbda_status_t;

endpackage

// ===== sv/sbda_ctrl.sv =====
// Sequencing state machine: load, double-dabble, leading-zero skip and character output.
module sbda_ctrl import sbda_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  sbda_status_t status_i,
  output sbda_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (status_i.conv_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zero digits, but always keep the units digit
        if (status_i.top_zero && !status_i.one_left) begin
          cmd_o.skip_shift = 1'b1;
        end else if (status_i.negative) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.one_left) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/sbda_dp.sv =====
// Datapath: magnitude and BCD shift registers, step counter and output register.
module sbda_dp import sbda_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ValueWidth-1:0] value_i,
  input  sbda_cmd_t             cmd_i,
  output sbda_status_t          status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CharWidth-1:0]  out_char_o,
  output logic                  out_last_o
);

  logic [ValueWidth-1:0]  mag_q, mag_d;
  logic [BcdWidth-1:0]    bcd_q, bcd_d, bcd_adj;
  logic [StepWidth-1:0]   step_q, step_d;
  logic [DigCntWidth-1:0] ndig_q, ndig_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [CharWidth-1:0]   out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;
  logic [3:0]             top_digit;
  logic                   out_free;

  assign top_digit = bcd_q[BcdWidth-1 -: 4];
  assign out_free  = !out_valid_q || out_ready_i;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int g = 0; g < NumDigits; g++) begin
      if (bcd_q[4*g +: 4] >= 4'd5) begin
        bcd_adj[4*g +: 4] = bcd_q[4*g +: 4] + 4'd3;
      end else begin
        bcd_adj[4*g +: 4] = bcd_q[4*g +: 4];
      end
    end
  end

  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    step_d      = step_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.load) begin
      neg_d  = value_i[ValueWidth-1];
      mag_d  = value_i[ValueWidth-1] ? (~value_i + 1'b1) : value_i;
      bcd_d  = '0;
      step_d = '0;
      ndig_d = DigCntWidth'(NumDigits);
    end

    if (cmd_i.conv_step) begin
      bcd_d  = {bcd_adj[BcdWidth-2:0], mag_q[ValueWidth-1]};
      mag_d  = {mag_q[ValueWidth-2:0], 1'b0};
      step_d = step_q + 1'b1;
    end

    if (cmd_i.skip_shift) begin
      bcd_d  = {bcd_q[BcdWidth-5:0], 4'd0};
      ndig_d = ndig_q - 1'b1;
    end

    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      out_char_d  = CharMinus;
      out_last_d  = 1'b0;
    end

    if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      out_char_d  = CharZero + {2'b00, top_digit};
      out_last_d  = (ndig_q == DigCntWidth'(1));
      bcd_d       = {bcd_q[BcdWidth-5:0], 4'd0};
      ndig_d      = ndig_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
      ndig_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      ndig_q      <= ndig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign status_o.conv_done = (step_q == {StepWidth{1'b1}});
  assign status_o.top_zero  = (top_digit == 4'd0);
  assign status_o.one_left  = (ndig_q == DigCntWidth'(1));
  assign status_o.negative  = neg_q;
  assign status_o.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit_digit || cmd_i.emit_sign) |-> out_free)
    else $error("character issued while output register is occupied");

  a_digit_is_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> (top_digit <= 4'd9))
    else $error("BCD digit out of range at output");

  a_skip_only_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.skip_shift |-> (top_digit == 4'd0) && (ndig_q > DigCntWidth'(1)))
    else $error("non-zero or units digit dropped");

  a_conv_full_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.conv_step |-> (ndig_q == DigCntWidth'(NumDigits)))
    else $error("conversion step after digits were consumed");

endmodule

// ===== sv/signed_binary_to_decimal_ascii.sv =====
// Top level of the signed 64-bit integer to decimal ASCII text converter.
// Takes one signed 64-bit value per request and returns its decimal text, one
// character per output request, most significant first: a '-' for negative
// values, then the digits with no leading zeros ("0" for zero); tlast marks the
// final character. Items are handled one at a time. After acceptance the value
// is converted by a bit-serial shift-and-add-3 loop over all of its bits, then
// leading zero digits are dropped one per cycle (up to 19), then one character
// is issued per cycle while the output is not stalled. The next value is
// accepted only after the last character of the current one has been issued.
module signed_binary_to_decimal_ascii import sbda_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [63:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [5:0] char_code, [7:6] zero
  output logic        m_axis_tlast_o   // last
);

  sbda_cmd_t            cmd;
  sbda_status_t         status;
  logic [CharWidth-1:0] out_char;

  sbda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sbda_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, out_char};

endmodule

// ===== sim/signed_binary_to_decimal_ascii_tb.sv =====
// Self-checking bench for the signed 64-bit to decimal ASCII converter.
module signed_binary_to_decimal_ascii_tb import sbda_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  class DecimalTextScoreboard;
    typedef struct {
      logic [CharWidth-1:0] code;
      logic                 last;
    } text_char_t;

    text_char_t  pending_chars[$];
    int unsigned errors;
    int unsigned values_taken;
    int unsigned negatives_taken;
    int unsigned chars_checked;

    // Expand one accepted value into the characters of its decimal text.
    function void note_value(logic [ValueWidth-1:0] value);
      logic [ValueWidth-1:0] magnitude;
      logic [3:0]            digit[NumDigits];
      int                    n_digits;
      text_char_t            c;
      magnitude = value[ValueWidth-1] ? (~value + 64'd1) : value;
      n_digits  = 0;
      do begin
        digit[n_digits] = 4'(magnitude % 64'd10);
        magnitude       = magnitude / 64'd10;
        n_digits++;
      end while (magnitude != 0 && n_digits < NumDigits);
      if (value[ValueWidth-1]) begin
        c.code = CharMinus;
        c.last = 1'b0;
        pending_chars.push_back(c);
        negatives_taken++;
      end
      for (int i = n_digits - 1; i >= 0; i--) begin
        c.code = CharZero + CharWidth'(digit[i]);
        c.last = (i == 0);
        pending_chars.push_back(c);
      end
      values_taken++;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_char(logic [7:0] data, logic last);
      text_char_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last %0b", data, last));
        return;
      end
      want = pending_chars.pop_front();
      if (data[CharWidth-1:0] !== want.code)
        report($sformatf("char_code %0d, want %0d", data[CharWidth-1:0], want.code));
      if (data[7:CharWidth] !== '0)
        report($sformatf("padding bits %b not zero", data[7:CharWidth]));
      if (last !== want.last)
        report($sformatf("last %0b, want %0b", last, want.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  DecimalTextScoreboard text_board;
  int unsigned          recv_idle_pct = 0;
  bit                   long_hold_req = 1'b0;
  bit                   long_hold_done = 1'b0;
  int unsigned          hold_left = 0;

  signed_binary_to_decimal_ascii dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Sample the output request, then pick the ready level for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      text_board.check_char(m_axis_tdata, m_axis_tlast);
    if (long_hold_req && !long_hold_done) begin
      hold_left      = 400;
      long_hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one value, idling beforehand at random, and hold it until taken.
  task automatic send_value(logic [63:0] value, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    text_board.note_value(value);
  endtask

  // Mostly values of varied length, some near powers of ten, some raw.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [63:0] p;
    int unsigned pick;
    pick = $urandom_range(9);
    v    = {$urandom, $urandom};
    if (pick < 6) begin
      v = v >> $urandom_range(63);
      if ($urandom_range(1) != 0) v = -v;
    end else if (pick < 8) begin
      p = 64'd1;
      repeat ($urandom_range(18)) p = p * 64'd10;
      v = p + 64'($urandom_range(2)) - 64'd1;
      if ($urandom_range(1) != 0) v = -v;
    end
    return v;
  endfunction

  task automatic random_phase(int unsigned n, int unsigned send_idle, int unsigned recv_idle);
    recv_idle_pct = recv_idle;
    repeat (n) send_value(random_value(), send_idle);
  endtask

  logic [63:0] directed_values[] = '{
    64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, 64'd99, 64'd100, -64'd100,
    64'd12345, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
    64'd999999999999999999, 64'd1000000000000000000,
    -64'd999999999999999999, -64'd1000000000000000000,
    64'd1234567890123456789, -64'd4294967296, 64'd4294967295
  };

  initial begin
    text_board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    recv_idle_pct = 84;
    foreach (directed_values[i]) send_value(directed_values[i], 21);
    random_phase(90, 21, 84);
    // Stall the output for a long stretch while values keep being offered.
    long_hold_req = 1'b1;
    random_phase(95, 84, 21);
    random_phase(95, 0, 0);
    s_axis_tvalid <= 1'b0;

    while (text_board.pending_chars.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("Converted %0d values (%0d negative) into %0d characters,",
             text_board.values_taken, text_board.negatives_taken,
             text_board.chars_checked);
    $display("covering zero, both extremes, powers of ten and a long output stall.");
    if (text_board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out waiting for the converter.");
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== signed_binary_to_decimal_ascii.f =====
sv/sbda_pkg.sv
sv/sbda_ctrl.sv
sv/sbda_dp.sv
sv/signed_binary_to_decimal_ascii.sv
sim/signed_binary_to_decimal_ascii_tb.sv
